FILE: rtl/core/arq_pkg.sv
package arq_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int SLOT_PERIOD     = 10;
  localparam int MAX_RESULTS     = 4;

  localparam logic [1:0] FN_ENQ    = 2'd0;
  localparam logic [1:0] FN_ACK    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;
  localparam logic [1:0] FN_TICK   = 2'd3;

  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_SENT    = 3'd1;
  localparam logic [2:0] KIND_DROPPED = 3'd2;
  localparam logic [2:0] KIND_REJECT  = 3'd3;
  localparam logic [2:0] KIND_REMOVED = 3'd4;

  localparam logic [2:0] REG_ACK_HOLD = 3'd0;
  localparam logic [2:0] REG_RETRY    = 3'd1;
  localparam logic [2:0] REG_ACK_TYPE = 3'd2;
  localparam logic [2:0] REG_PROP     = 3'd3;
  localparam logic [2:0] REG_DOCK     = 3'd4;
  localparam logic [2:0] REG_WILD     = 3'd5;

  typedef struct packed {
    logic [7:0]  mtype;
    logic [7:0]  receiver;
    logic [31:0] stamp;
    logic [7:0]  limit;
    logic [7:0]  attempts;
    logic [7:0]  tag;
    logic [15:0] handle;
  } entry_t;

  // Per-cell command, broadcast along one channel's row of cells.
  typedef struct packed {
    logic   push_front;  // shift toward tail, load slot 0
    logic   push_tail;   // load slot at fill
    logic   shift_down;  // close a gap at del_pos
    logic   upd_head;    // rewrite slot 0 attempts/stamp
    entry_t wr;
  } cell_cmd_t;

  // slot = elapsed mod 10, via reciprocal: q = (x*0xCCCCCCCD)>>35
  function automatic logic [31:0] mod10_q(input logic [31:0] x);
    logic [63:0] p;
    p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
    return 32'(p >> 35);
  endfunction

endpackage

FILE: rtl/core/ack_retransmit_queue.sv
// ack_retransmit_queue: per-channel transmit queues with ack and retry.
// Input channel (in_valid/in_ready) carries one command item: enqueue,
// ack received, remove by type, or tick. Results leave on out_valid/
// out_ready, one or more per item; out_last_result marks the final one.
// Each channel's queue is a row of cells; slot 0 is the head. Insertion
// at the front shifts the whole row by one cell; deletion shifts the
// cells from the deleted slot onward down by one. An enqueue result is
// loaded at the edge that accepts the item. Ack/remove check one slot
// per cycle (on a hit the next entry moves into the freed slot) and
// report once the scan passes the fill. A tick visits each channel head
// in turn: slot math (TCALC), then action (TACT); EMIT sends the last
// result. Tick results are held one behind, so the last one can carry
// the final-result flag. One item is in work at a time; ready rises
// again once the machine is idle and the output register is empty or
// being taken. Reset (synchronous, rst_n low) empties all queues,
// zeroes the time counter and loads the register defaults; no clearing
// pass is needed. A stalled receiver holds the output register; a step
// that loads a result waits until the pending one is taken. The user must
// write configuration only while idle; the block does not enforce it.
module ack_retransmit_queue #(
  parameter int CHANNELS    = arq_pkg::CHANNELS_DEF,
  parameter int QUEUE_DEPTH = arq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_channel,
  input  logic [7:0]  in_msg_type,
  input  logic [7:0]  in_receiver_id,
  input  logic [7:0]  in_retry_limit,
  input  logic [7:0]  in_tag_byte,
  input  logic [15:0] in_payload_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_out_channel,
  output logic [7:0]  out_out_type,
  output logic [7:0]  out_out_receiver,
  output logic [15:0] out_out_handle,
  output logic [7:0]  out_attempt_count,
  output logic [3:0]  out_removed_count,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import arq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_TCALC, S_TACT, S_EMIT} state_t;

  // configuration
  logic [31:0] ack_hold_r, retry_r;
  logic [7:0]  ack_type_r, prop_r, dock_r, wild_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_hold_r <= '0; retry_r <= 32'd10;
      ack_type_r <= 8'd1; prop_r <= 8'd2; dock_r <= 8'd3; wild_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACK_HOLD: ack_hold_r <= cfg_data;
        REG_RETRY:    retry_r    <= cfg_data;
        REG_ACK_TYPE: ack_type_r <= cfg_data[7:0];
        REG_PROP:     prop_r     <= cfg_data[7:0];
        REG_DOCK:     dock_r     <= cfg_data[7:0];
        REG_WILD:     wild_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // queue rows
  cell_cmd_t   cmd    [CHANNELS];
  logic [PW:0] fill_r [CHANNELS];
  logic [PW:0] fill_nxt [CHANNELS];
  logic [PW-1:0] del_pos;
  entry_t      slots  [CHANNELS][QUEUE_DEPTH];

  genvar gc;
  generate
    for (gc = 0; gc < CHANNELS; gc++) begin : g_row
      arq_row #(.DEPTH(QUEUE_DEPTH), .PW(PW)) u_row (
        .clk(clk), .cmd(cmd[gc]), .fill(fill_r[gc]), .del_pos(del_pos),
        .slots(slots[gc]));
    end
  endgenerate

  // control
  state_t      state_r;
  logic [1:0]  func_r, ch_r;
  logic [7:0]  type_r, tag_r;
  logic [PW:0] k_r;
  logic [3:0]  removed_r;
  logic [CW:0] c_r;
  logic [2:0]  nres_r;
  logic [31:0] time_r;
  logic [31:0] elapsed_r, quot_r;

  // tick result held one behind the action that made it
  logic        hold_v_r;
  logic [2:0]  hold_kind_r;
  logic [1:0]  hold_ch_r;
  logic [7:0]  hold_type_r, hold_recv_r, hold_att_r;
  logic [15:0] hold_handle_r;

  logic        obuf_free;
  assign obuf_free = !out_valid || out_ready;
  assign in_ready  = (state_r == S_IDLE) && obuf_free;

  logic [2:0]  o_kind;
  logic [1:0]  o_ch;
  logic [7:0]  o_type, o_recv, o_att;
  logic [15:0] o_handle;
  logic [3:0]  o_rem;
  logic        o_last, o_load;

  logic [CW-1:0] ci;
  logic [CW-1:0] in_ci;
  logic        in_ch_ok, cur_ch_ok;
  entry_t      head, scan_e, new_e;
  logic        hit;
  logic [31:0] slot_v;
  logic        go;
  logic [2:0]  act_kind;
  logic [7:0]  act_att;
  logic        tact_fire;

  assign ci        = c_r[CW-1:0];
  assign in_ci     = CW'(in_channel);
  assign in_ch_ok  = {2'b0, in_channel} < 4'(CHANNELS);
  assign cur_ch_ok = {2'b0, ch_r} < 4'(CHANNELS);
  assign head      = slots[ci][0];
  assign scan_e    = slots[CW'(ch_r)][k_r[PW-1:0]];
  assign del_pos   = (state_r == S_SCAN) ? k_r[PW-1:0] : '0;
  assign slot_v    = elapsed_r - (quot_r * 32'd10);

  // Advance past a head when it does nothing, when results are capped,
  // or when the held result can move on to the output register.
  assign tact_fire = (state_r == S_TACT) &&
                     ((fill_r[ci] == '0) || (act_kind == KIND_NONE) ||
                      (nres_r >= 3'(MAX_RESULTS)) || !hold_v_r || obuf_free);

  always_comb begin
    new_e.mtype = in_msg_type; new_e.receiver = in_receiver_id;
    new_e.stamp = time_r; new_e.limit = in_retry_limit;
    new_e.attempts = '0; new_e.tag = in_tag_byte;
    new_e.handle = in_payload_handle;
    if (func_r == FN_ACK) begin
      hit = (scan_e.limit != 8'd0) && (scan_e.mtype == type_r) &&
            ((type_r != prop_r) || (scan_e.tag == tag_r));
    end else begin
      hit = (scan_e.mtype == type_r) &&
            ((tag_r == wild_r) || (scan_e.tag == tag_r));
    end
    act_kind = KIND_NONE;
    act_att  = head.attempts;
    go       = 1'b0;
    if (head.limit == 8'd0) begin
      if (head.mtype == dock_r)          go = (slot_v == 32'(2 * 32'(ci)));
      else if (head.mtype == ack_type_r) go = (elapsed_r > ack_hold_r);
      else                               go = 1'b1;
      if (go) act_kind = KIND_SENT;
    end else if (head.attempts < head.limit) begin
      if (elapsed_r > retry_r) begin
        act_kind = KIND_SENT;
        act_att  = head.attempts + 8'd1;
      end
    end else begin
      act_kind = KIND_DROPPED;
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      cmd[c] = '0;
      cmd[c].wr = new_e;
      fill_nxt[c] = fill_r[c];
    end
    o_load = 1'b0; o_kind = KIND_NONE; o_ch = '0; o_type = '0; o_recv = '0;
    o_handle = '0; o_att = '0; o_rem = '0; o_last = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready && in_func == FN_ENQ) begin
          o_load = 1'b1; o_ch = in_channel; o_type = in_msg_type; o_last = 1'b1;
          if (!in_ch_ok || fill_r[in_ci] >= (PW+1)'(QUEUE_DEPTH)) begin
            o_kind = KIND_REJECT;
          end else begin
            if (in_msg_type == ack_type_r) cmd[in_ci].push_front = 1'b1;
            else                           cmd[in_ci].push_tail  = 1'b1;
            fill_nxt[in_ci] = fill_r[in_ci] + 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!cur_ch_ok || k_r >= fill_r[CW'(ch_r)]) begin
          if (obuf_free) begin
            o_load = 1'b1; o_kind = KIND_REMOVED; o_ch = ch_r; o_type = type_r;
            o_rem = removed_r; o_last = 1'b1;
          end
        end else if (hit) begin
          cmd[CW'(ch_r)].shift_down = 1'b1;
          fill_nxt[CW'(ch_r)] = fill_r[CW'(ch_r)] - 1'b1;
        end
      end
      S_TACT: begin
        if (tact_fire && fill_r[ci] != '0 && act_kind != KIND_NONE) begin
          // push the held result out as the new one takes its place
          o_load = hold_v_r && (nres_r < 3'(MAX_RESULTS));
          o_kind = hold_kind_r; o_ch = hold_ch_r; o_type = hold_type_r;
          o_recv = hold_recv_r; o_handle = hold_handle_r; o_att = hold_att_r;
          if (act_kind == KIND_SENT && head.limit != 8'd0) begin
            cmd[ci].upd_head = 1'b1;
            cmd[ci].wr = head;
            cmd[ci].wr.attempts = act_att;
            cmd[ci].wr.stamp = time_r;
          end else begin
            cmd[ci].shift_down = 1'b1;
            fill_nxt[ci] = fill_r[ci] - 1'b1;
          end
        end
      end
      S_EMIT: begin
        // final result: the held one, or a kind-0 item if no head acted
        if (obuf_free) begin
          o_load = 1'b1; o_last = 1'b1;
          if (hold_v_r) begin
            o_kind = hold_kind_r; o_ch = hold_ch_r; o_type = hold_type_r;
            o_recv = hold_recv_r; o_handle = hold_handle_r; o_att = hold_att_r;
          end
        end
      end
      default: ;
    endcase
  end

  // del_pos is zero in TACT, so shift_down pops the head there.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      time_r  <= '0;
      out_valid <= 1'b0;
      hold_v_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) fill_r[c] <= '0;
    end else begin
      for (int c = 0; c < CHANNELS; c++) fill_r[c] <= fill_nxt[c];
      if (o_load) begin
        out_valid <= 1'b1;
        out_kind <= o_kind; out_out_channel <= o_ch; out_out_type <= o_type;
        out_out_receiver <= o_recv; out_out_handle <= o_handle;
        out_attempt_count <= o_att; out_removed_count <= o_rem;
        out_last_result <= o_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func_r <= in_func; ch_r <= in_channel; type_r <= in_msg_type;
            tag_r <= in_tag_byte; k_r <= '0; removed_r <= '0;
            c_r <= '0; nres_r <= '0;
            if (in_func == FN_ACK || in_func == FN_REMOVE) begin
              state_r <= S_SCAN;
            end else if (in_func == FN_TICK) begin
              time_r  <= time_r + 32'd1;
              state_r <= S_TCALC;
            end
          end
        end
        S_SCAN: begin
          if (!cur_ch_ok || k_r >= fill_r[CW'(ch_r)]) begin
            if (obuf_free) state_r <= S_IDLE;
          end else if (hit) begin
            if (removed_r != 4'd15) removed_r <= removed_r + 4'd1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_TCALC: begin
          elapsed_r <= time_r - head.stamp;
          quot_r    <= mod10_q(time_r - head.stamp);
          state_r   <= S_TACT;
        end
        S_TACT: begin
          if (tact_fire) begin
            if (fill_r[ci] != '0 && act_kind != KIND_NONE &&
                nres_r < 3'(MAX_RESULTS)) begin
              nres_r        <= nres_r + 3'd1;
              hold_v_r      <= 1'b1;
              hold_kind_r   <= act_kind;
              hold_ch_r     <= 2'(ci);
              hold_type_r   <= head.mtype;
              hold_recv_r   <= head.receiver;
              hold_handle_r <= head.handle;
              hold_att_r    <= act_att;
            end
            if (c_r == (CW+1)'(CHANNELS - 1)) begin
              state_r <= S_EMIT;
            end else begin
              c_r <= c_r + 1'b1;
              state_r <= S_TCALC;
            end
          end
        end
        S_EMIT: begin
          if (obuf_free) begin
            hold_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // hold the result steady while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_kind, out_out_channel, out_out_type, out_out_receiver,
               out_out_handle, out_attempt_count, out_removed_count,
               out_last_result}));

  // take no new item while one is in work
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready);

  // never report more than the cap on a tick
  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TACT |-> nres_r <= 3'(MAX_RESULTS));

  // drop the held result before going idle
  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !hold_v_r);
endmodule

FILE: rtl/core/arq_cell.sv
// One queue slot: holds an entry and takes its neighbor's on a shift.
module arq_cell (
  input  logic            clk,
  input  logic            load,
  input  arq_pkg::entry_t load_val,
  output arq_pkg::entry_t val
);
  import arq_pkg::*;

  entry_t val_r;

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= load_val;
    end
  end

  assign val = val_r;
endmodule

FILE: rtl/core/arq_row.sv
// One channel's queue as a chain of cells; slot 0 is the head.
module arq_row #(
  parameter int DEPTH = arq_pkg::QUEUE_DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  arq_pkg::cell_cmd_t cmd,
  input  logic [PW:0]       fill,
  input  logic [PW-1:0]     del_pos,
  output arq_pkg::entry_t   slots [DEPTH]
);
  import arq_pkg::*;

  entry_t cur [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   ld;
      entry_t lv;
      always_comb begin
        ld = 1'b0;
        lv = cmd.wr;
        if (cmd.push_front) begin
          ld = 1'b1;
          if (g > 0) lv = cur[(g > 0) ? g-1 : 0];
        end else if (cmd.push_tail) begin
          ld = (fill[PW-1:0] == PW'(g));
        end else if (cmd.shift_down) begin
          ld = (PW'(g) >= del_pos) && (g < DEPTH-1);
          lv = cur[(g < DEPTH-1) ? g+1 : g];
        end else if (cmd.upd_head) begin
          ld = (g == 0);
        end
      end
      arq_cell u_cell (.clk(clk), .load(ld), .load_val(lv), .val(cur[g]));
      assign slots[g] = cur[g];
    end
  endgenerate
endmodule
